// File: design/ksb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_pkg
// Shared types, codes and key translation tables for the keyboard service
// buffer.
// ----------------------------------------------------------------------------
package ksb_pkg;

  localparam int RING_SLOTS_DEF = 16;
  localparam int CMD_DEPTH      = 2;
  localparam int RES_DEPTH      = 2;
  localparam int CFG_IDX_W      = 2;

  // Service function codes
  localparam logic [7:0] OP_PEEK      = 8'h01;
  localparam logic [7:0] OP_PEEK_EXT  = 8'h11;
  localparam logic [7:0] OP_FLAGS     = 8'h02;
  localparam logic [7:0] OP_EXT_FLAGS = 8'h12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_SHIFT = CFG_IDX_W'(1);

  // Special key words and scan codes
  localparam logic [15:0] KEY_ENTER = 16'h1c0d;
  localparam logic [15:0] KEY_BKSP  = 16'h0e08;
  localparam logic [15:0] KEY_ESC   = 16'h011b;
  localparam logic [7:0]  SCAN_ONE   = 8'h02;
  localparam logic [7:0]  SCAN_ZERO  = 8'h0b;
  localparam logic [7:0]  SCAN_SPACE = 8'h39;
  localparam logic [7:0]  SCAN_TAB   = 8'h0f;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] low_byte;
    logic       uart_ready;
    logic [7:0] uart_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] key_word;
    logic        key_ready;
    logic        zero_flag;
    logic        took_uart_byte;
  } out_t;

  typedef enum logic [1:0] {
    CLS_READ  = 2'd0,
    CLS_PEEK  = 2'd1,
    CLS_FLAGS = 2'd2,
    CLS_EXT   = 2'd3
  } cls_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    cls_t        cls;
    logic [7:0]  opcode;
    logic [7:0]  low_byte;
    logic        uart_ready;
    logic [15:0] key_word;   // translated serial byte
  } cmd_t;

  function automatic logic [7:0] letter_scan(input logic [4:0] idx);
    logic [7:0] s;
    case (idx)
      5'd0:  s = 8'h1e; 5'd1:  s = 8'h30; 5'd2:  s = 8'h2e; 5'd3:  s = 8'h20;
      5'd4:  s = 8'h12; 5'd5:  s = 8'h21; 5'd6:  s = 8'h22; 5'd7:  s = 8'h23;
      5'd8:  s = 8'h17; 5'd9:  s = 8'h24; 5'd10: s = 8'h25; 5'd11: s = 8'h26;
      5'd12: s = 8'h32; 5'd13: s = 8'h31; 5'd14: s = 8'h18; 5'd15: s = 8'h19;
      5'd16: s = 8'h10; 5'd17: s = 8'h13; 5'd18: s = 8'h1f; 5'd19: s = 8'h14;
      5'd20: s = 8'h16; 5'd21: s = 8'h2f; 5'd22: s = 8'h11; 5'd23: s = 8'h2d;
      5'd24: s = 8'h15; 5'd25: s = 8'h2c;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // US layout scan code of an ASCII byte, zero when there is none
  function automatic logic [7:0] scan_of(input logic [7:0] c);
    logic [7:0] s;
    if (c >= 8'h31 && c <= 8'h39) begin
      s = SCAN_ONE + (c - 8'h31);
    end else if (c == 8'h30) begin
      s = SCAN_ZERO;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s = letter_scan(5'(c - 8'h61));
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      s = letter_scan(5'(c - 8'h41));
    end else begin
      case (c)
        8'h2d, 8'h5f: s = 8'h0c;
        8'h3d, 8'h2b: s = 8'h0d;
        8'h5b, 8'h7b: s = 8'h1a;
        8'h5d, 8'h7d: s = 8'h1b;
        8'h3b, 8'h3a: s = 8'h27;
        8'h27, 8'h22: s = 8'h28;
        8'h60, 8'h7e: s = 8'h29;
        8'h5c, 8'h7c: s = 8'h2b;
        8'h2c, 8'h3c: s = 8'h33;
        8'h2e, 8'h3e: s = 8'h34;
        8'h2f, 8'h3f: s = 8'h35;
        8'h20:        s = SCAN_SPACE;
        8'h09:        s = SCAN_TAB;
        default:      s = 8'h00;
      endcase
    end
    return s;
  endfunction

  function automatic logic [15:0] serial_word(input logic [7:0] c);
    logic [15:0] w;
    if (c == 8'h0d || c == 8'h0a) begin
      w = KEY_ENTER;
    end else if (c == 8'h08 || c == 8'h7f) begin
      w = KEY_BKSP;
    end else if (c == 8'h1b) begin
      w = KEY_ESC;
    end else begin
      w = {scan_of(c), c};
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/keyboard_service_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_service_buffer
// Keyboard service request handler fed by a serial receiver.
// ----------------------------------------------------------------------------
// Requests enter through a push/full queue interface and every request
// produces exactly one result, read through an empty/pop queue interface in
// request order. A request is classified and its serial byte translated on
// entry, then waits in a two-entry command queue; the back end executes one
// request at a time and writes the result into a two-entry result queue.
// Flag queries, an empty ring and a key arriving from the serial byte are
// served in the back end's idle state; returning a key already held in the
// ring passes through the data state as well, set by the registered read of
// the key ring RAM. A request passes through the command queue register, the
// back end and the result queue register before empty goes low.
// A blocked read returns key_ready low and the caller retries. The shift
// state registers are written through the cfg port (always ready); the user
// must write them only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module keyboard_service_buffer import ksb_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request side
  input  wire logic                 push,
  output logic                      full,
  input  wire in_t                  item,
  // result side
  output logic                      empty,
  input  wire logic                 pop,
  output out_t                      result,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic       cmd_pop;
  logic       cmd_empty;
  cmd_t       cmd;
  logic       res_full;
  logic       res_push;
  out_t       res;
  logic [7:0] shift_flags;
  logic [7:0] ext_shift_flags;
  logic [$bits(out_t)-1:0] res_rdata;

  // Shift state registers; writes to unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flags     <= '0;
      ext_shift_flags <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHIFT:     shift_flags     <= cfg_data;
        CFG_EXT_SHIFT: ext_shift_flags <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Front end: classify and translate, queue the command
  ksb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // Back end: key ring and result formation
  ksb_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .shift_flags     (shift_flags),
    .ext_shift_flags (ext_shift_flags),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (res)
  );

  // Result queue decouples the back end from the consumer
  ksb_queue #(
    .WIDTH ($bits(out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (res_rdata)
  );

  assign result = out_t'(res_rdata);

endmodule
`default_nettype wire

// File: design/ksb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ksb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/ksb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_queue
// Small register FIFO; the oldest entry is shown while empty is low.
// ----------------------------------------------------------------------------
module ksb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: design/ksb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_front
// Takes service requests, classifies the function code, translates the
// serial byte and queues the result for the back end.
// ----------------------------------------------------------------------------
module ksb_front import ksb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  item,
  input  wire logic cmd_pop,
  output logic      cmd_empty,
  output cmd_t      cmd
);

  cmd_t                cls_cmd;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cls_cmd.opcode     = item.opcode;
    cls_cmd.low_byte   = item.low_byte;
    cls_cmd.uart_ready = item.uart_ready;
    cls_cmd.key_word   = serial_word(item.uart_byte);
    unique case (item.opcode) inside
      OP_PEEK, OP_PEEK_EXT: cls_cmd.cls = CLS_PEEK;
      OP_FLAGS:             cls_cmd.cls = CLS_FLAGS;
      OP_EXT_FLAGS:         cls_cmd.cls = CLS_EXT;
      default:              cls_cmd.cls = CLS_READ;
    endcase
  end

  ksb_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cls_cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (q_rdata)
  );

  assign cmd = cmd_t'(q_rdata);

endmodule
`default_nettype wire

// File: design/ksb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_back
// Carries out classified requests against the key ring and forms results.
// ----------------------------------------------------------------------------
module ksb_back import ksb_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_empty,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  input  wire logic [7:0] shift_flags,
  input  wire logic [7:0] ext_shift_flags,
  input  wire logic       res_full,
  output logic            res_push,
  output out_t            res
);

  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DATA = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] head_slot, head_slot_next;
  logic [SLOT_W-1:0] tail_slot, tail_slot_next;
  logic              pend_read, pend_read_next;
  logic              ring_we;
  logic [15:0]       ring_rdata;
  logic              ring_empty;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign ring_empty = (head_slot == tail_slot);

  always_comb begin
    state_next     = state;
    head_slot_next = head_slot;
    tail_slot_next = tail_slot;
    pend_read_next = pend_read;
    cmd_pop        = 1'b0;
    ring_we        = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    unique case (state)
      S_IDLE: begin
        // a free result slot is reserved before the request is taken
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.cls) inside
            CLS_FLAGS: begin
              res_push      = 1'b1;
              res.key_word  = {cmd.opcode, shift_flags};
              res.key_ready = 1'b1;
            end
            CLS_EXT: begin
              res_push      = 1'b1;
              res.key_word  = {ext_shift_flags, shift_flags};
              res.key_ready = 1'b1;
            end
            CLS_PEEK, CLS_READ: begin
              if (!ring_empty) begin
                // key waiting: RAM is reading the head slot this cycle
                state_next     = S_DATA;
                pend_read_next = (cmd.cls == CLS_READ);
              end else if (cmd.uart_ready) begin
                // empty ring: the new key is the head, bypass the RAM
                ring_we            = 1'b1;
                tail_slot_next     = next_slot(tail_slot);
                res_push           = 1'b1;
                res.key_word       = cmd.key_word;
                res.key_ready      = 1'b1;
                res.took_uart_byte = 1'b1;
                if (cmd.cls == CLS_READ) begin
                  head_slot_next = next_slot(head_slot);
                end
              end else begin
                res_push = 1'b1;
                if (cmd.cls == CLS_PEEK) begin
                  res.key_word  = {cmd.opcode, cmd.low_byte};
                  res.zero_flag = 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_DATA: begin
        res_push      = 1'b1;
        res.key_word  = ring_rdata;
        res.key_ready = 1'b1;
        if (pend_read) begin
          head_slot_next = next_slot(head_slot);
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= '0;
      tail_slot <= '0;
      pend_read <= 1'b0;
    end else begin
      state     <= state_next;
      head_slot <= head_slot_next;
      tail_slot <= tail_slot_next;
      pend_read <= pend_read_next;
    end
  end

  ksb_ram #(
    .WIDTH (16),
    .DEPTH (RING_SLOTS)
  ) u_key_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail_slot),
    .wdata (cmd.key_word),
    .raddr (head_slot),
    .rdata (ring_rdata)
  );

endmodule
`default_nettype wire

// File: design/ksb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_checker
// Port-level checks for the keyboard service buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ksb_checker import ksb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire out_t result
);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result holds until transferred
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before transfer");

  // a result cannot both report a key and report none
  a_zf_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(result.zero_flag && result.key_ready))
    else $error("zero_flag set with key_ready");

  // a consumed serial byte always delivers a key
  a_took_key: assert property (@(posedge clk) disable iff (rst)
    !empty && result.took_uart_byte |-> result.key_ready)
    else $error("serial byte taken without key");

  // no request can be lost: with nothing pending, a transfer in fills a slot
  a_push_progress: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> !full || !empty || $past(!empty))
    else $error("request queue full with no result pending");

endmodule

bind keyboard_service_buffer ksb_checker u_checker (.*);
`default_nettype wire

// File: sim/ksb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ksb_checker
// Watches the request, result and configuration channels of the keyboard
// service buffer, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_ksb_checker import ksb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic                 full,
  input  wire in_t                  item,
  input  wire logic                 empty,
  input  wire logic                 pop,
  input  wire out_t                 result,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output int                        fail_count,
  output int                        pending
);

  localparam int KEY_SLOTS = RING_SLOTS_DEF;
  typedef logic [$clog2(KEY_SLOTS)-1:0] slot_t;

  // scan codes of a..z, first letter in the top byte
  localparam logic [26*8-1:0] ALPHA_SCAN = {
    8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17,
    8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13,
    8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c
  };

  logic [15:0] key_slots [KEY_SLOTS];
  slot_t       rd_slot;
  slot_t       wr_slot;
  logic [7:0]  shift_reg;
  logic [7:0]  ext_shift_reg;
  out_t        key_results_q [$];

  function automatic logic [7:0] us_scan(input logic [7:0] c);
    logic [7:0] s;
    int         k;
    s = 8'h00;
    k = -1;
    if (c >= 8'h61 && c <= 8'h7a) k = int'(c) - 'h61;
    if (c >= 8'h41 && c <= 8'h5a) k = int'(c) - 'h41;
    if (c >= 8'h31 && c <= 8'h39) begin
      s = SCAN_ONE + (c - 8'h31);
    end else if (c == 8'h30) begin
      s = SCAN_ZERO;
    end else if (k >= 0) begin
      s = ALPHA_SCAN[8*(25-k) +: 8];
    end else begin
      case (c)
        8'h2d, 8'h5f: s = 8'h0c;
        8'h3d, 8'h2b: s = 8'h0d;
        8'h5b, 8'h7b: s = 8'h1a;
        8'h5d, 8'h7d: s = 8'h1b;
        8'h3b, 8'h3a: s = 8'h27;
        8'h27, 8'h22: s = 8'h28;
        8'h60, 8'h7e: s = 8'h29;
        8'h5c, 8'h7c: s = 8'h2b;
        8'h2c, 8'h3c: s = 8'h33;
        8'h2e, 8'h3e: s = 8'h34;
        8'h2f, 8'h3f: s = 8'h35;
        8'h20:        s = SCAN_SPACE;
        8'h09:        s = SCAN_TAB;
        default:      s = 8'h00;
      endcase
    end
    return s;
  endfunction

  // CR/LF, BS/DEL and ESC map to fixed words, the rest to {scan, ascii}
  function automatic logic [15:0] key_of_byte(input logic [7:0] c);
    if (c == 8'h0d || c == 8'h0a) return KEY_ENTER;
    if (c == 8'h08 || c == 8'h7f) return KEY_BKSP;
    if (c == 8'h1b) return KEY_ESC;
    return {us_scan(c), c};
  endfunction

  function automatic slot_t next_slot_of(input slot_t s);
    return (int'(s) == KEY_SLOTS - 1) ? slot_t'(0) : slot_t'(s + 1'b1);
  endfunction

  // A serial byte is only taken into an empty ring
  task automatic take_serial(input in_t req, output logic took, output logic have_key);
    took     = 1'b0;
    have_key = 1'b0;
    if (rd_slot != wr_slot) begin
      have_key = 1'b1;
    end else if (req.uart_ready) begin
      took = 1'b1;
      if (next_slot_of(wr_slot) != rd_slot) begin
        key_slots[wr_slot] = key_of_byte(req.uart_byte);
        wr_slot            = next_slot_of(wr_slot);
        have_key           = 1'b1;
      end
    end
  endtask

  task automatic serve_request(input in_t req, output out_t res);
    logic took;
    logic have_key;
    res = '0;
    case (req.opcode)
      OP_PEEK, OP_PEEK_EXT: begin
        take_serial(req, took, have_key);
        res.took_uart_byte = took;
        if (have_key) begin
          res.key_word  = key_slots[rd_slot];
          res.key_ready = 1'b1;
        end else begin
          res.key_word  = {req.opcode, req.low_byte};
          res.zero_flag = 1'b1;
        end
      end
      OP_FLAGS: begin
        res.key_word  = {req.opcode, shift_reg};
        res.key_ready = 1'b1;
      end
      OP_EXT_FLAGS: begin
        res.key_word  = {ext_shift_reg, shift_reg};
        res.key_ready = 1'b1;
      end
      default: begin
        take_serial(req, took, have_key);
        res.took_uart_byte = took;
        if (have_key) begin
          res.key_word  = key_slots[rd_slot];
          res.key_ready = 1'b1;
          rd_slot       = next_slot_of(rd_slot);
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      rd_slot       = '0;
      wr_slot       = '0;
      shift_reg     = 8'h00;
      ext_shift_reg = 8'h00;
      key_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHIFT:     shift_reg     = cfg_data;
          CFG_EXT_SHIFT: ext_shift_reg = cfg_data;
          default:       ;
        endcase
      end
      if (push && !full) begin
        serve_request(item, want);
        key_results_q.push_back(want);
      end
      if (pop && !empty) begin
        if (key_results_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
        end else begin
          want = key_results_q.pop_front();
          check_field("key_word", want.key_word, result.key_word);
          check_field("key_ready", 16'(want.key_ready), 16'(result.key_ready));
          check_field("zero_flag", 16'(want.zero_flag), 16'(result.zero_flag));
          check_field("took_uart_byte", 16'(want.took_uart_byte),
                      16'(result.took_uart_byte));
        end
      end
    end
    pending <= key_results_q.size();
  end

endmodule

// File: sim/tb_keyboard_service_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_service_buffer
// Stimulus and verdict for the keyboard service buffer.
// ----------------------------------------------------------------------------
// A directed opening covers flag queries at reset and configured values,
// empty peeks and reads, serial bytes taken into an empty ring and ignored
// when a key is already held, and the special translations (enter,
// backspace, escape) plus the edges of the scan table. Four random phases
// follow, each under its own shift state setting, built mostly from
// keystroke sequences (peek with a byte waiting, peek again, read, retry on
// empty) mixed with raw noise requests. One phase holds the result side off
// for a long stretch so the block fills and stalls its input; another runs
// both sides with no idling. Prediction and comparison live in tb_ksb_checker.
// ----------------------------------------------------------------------------
module tb_keyboard_service_buffer;
  import ksb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any transfer
  localparam int HOLD_CYCLES     = 300;   // long result-side hold-off
  localparam int DRAIN_GAP       = 8;     // quiet wait after the last result
  localparam int ITEMS_PER_PHASE = 125;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_t                  item;
  logic                 empty;
  logic                 pop;
  out_t                 result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   fail_count;
  int                   pending;

  // handshake controls for the sender and receiver processes
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int items_sent;

  keyboard_service_buffer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tb_ksb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_t request(input logic [7:0] op, input logic [7:0] lo,
                                  input logic rdy, input logic [7:0] b);
    in_t r;
    r.opcode     = op;
    r.low_byte   = lo;
    r.uart_ready = rdy;
    r.uart_byte  = b;
    return r;
  endfunction

  // Mostly printable text, a fair share of control keys, the rest anything
  function automatic logic [7:0] random_key_byte();
    logic [7:0] ctrl [7];
    int         r;
    ctrl = '{8'h0d, 8'h0a, 8'h08, 8'h7f, 8'h1b, 8'h09, 8'h20};
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 55) return ctrl[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Any code that is not a peek or a flag query reads
  function automatic logic [7:0] random_read_opcode();
    logic [7:0] op;
    if ($urandom_range(0, 1)) return 8'h00;
    do begin
      op = 8'($urandom_range(0, 255));
    end while (op == OP_PEEK || op == OP_PEEK_EXT || op == OP_FLAGS ||
               op == OP_EXT_FLAGS);
    return op;
  endfunction

  function automatic logic [7:0] random_peek_opcode();
    return $urandom_range(0, 1) ? OP_PEEK : OP_PEEK_EXT;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with push still high, so back-to-back requests need no gap.
  task automatic send_request(input in_t req);
    while (!tx_steady && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop push, wait for every outstanding result, then let the pipe go quiet
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    int         start;
    logic [7:0] ch;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 99) < 70) begin
        // keystroke: byte arrives on a peek, then gets read out
        ch = random_key_byte();
        send_request(request(random_peek_opcode(), rnd8(), 1'b1, ch));
        if ($urandom_range(0, 1))
          send_request(request(random_peek_opcode(), rnd8(), 1'($urandom_range(0, 1)),
                               random_key_byte()));
        if ($urandom_range(0, 9) < 2)
          send_request(request($urandom_range(0, 1) ? OP_FLAGS : OP_EXT_FLAGS, rnd8(),
                               1'($urandom_range(0, 1)), rnd8()));
        send_request(request(random_read_opcode(), rnd8(), 1'($urandom_range(0, 1)),
                             random_key_byte()));
        if ($urandom_range(0, 9) < 3)
          send_request(request(random_read_opcode(), rnd8(), 1'b0, rnd8()));
      end else begin
        // noise: every field fully random
        send_request(request(rnd8(), rnd8(), 1'($urandom_range(0, 1)), rnd8()));
      end
    end
  endtask

  // Result side: random pops, one long hold-off on request, steady on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    rst        = 1'b1;
    push       = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SHIFT;
    cfg_data   = 8'h00;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // shift state straight out of reset
    send_request(request(OP_FLAGS, 8'hff, 1'b1, 8'h61));
    send_request(request(OP_EXT_FLAGS, 8'h00, 1'b0, 8'h00));
    settle();

    write_reg(CFG_SHIFT, 8'hff);
    write_reg(CFG_EXT_SHIFT, 8'h00);
    send_request(request(OP_FLAGS, 8'h00, 1'b0, 8'h00));
    send_request(request(OP_EXT_FLAGS, 8'hff, 1'b1, 8'hff));
    // empty ring, no serial byte: peek returns caller word, read retries
    send_request(request(OP_PEEK, 8'hff, 1'b0, 8'hff));
    send_request(request(OP_PEEK_EXT, 8'h00, 1'b0, 8'h0d));
    send_request(request(8'h00, 8'h5a, 1'b0, 8'h41));
    send_request(request(8'hff, 8'hff, 1'b0, 8'hff));
    // byte taken on peek, ignored while the key is held, then read out
    send_request(request(OP_PEEK, 8'h12, 1'b1, 8'h0d));
    send_request(request(OP_PEEK_EXT, 8'h34, 1'b1, 8'h78));
    send_request(request(8'h10, 8'h56, 1'b1, 8'h79));
    // read with a byte waiting takes and returns it at once
    send_request(request(8'h00, 8'h00, 1'b1, 8'h0a));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h08));
    send_request(request(8'h03, 8'h00, 1'b1, 8'h7f));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h1b));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h30));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h39));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h7a));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h41));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h20));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h09));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h7e));
    send_request(request(8'h00, 8'h00, 1'b1, 8'h00));
    send_request(request(8'h00, 8'h00, 1'b1, 8'hff));
    send_request(request(8'h80, 8'h00, 1'b1, 8'h80));
    settle();

    // receiver stalls early in this phase so the block backs up
    write_reg(CFG_SHIFT, 8'h00);
    write_reg(CFG_EXT_SHIFT, 8'hff);
    hold_req = 1'b1;
    random_phase(ITEMS_PER_PHASE);
    settle();

    // no idling on either side
    write_reg(CFG_SHIFT, 8'h5a);
    write_reg(CFG_EXT_SHIFT, 8'ha5);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_phase(ITEMS_PER_PHASE);
    settle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    write_reg(CFG_SHIFT, rnd8());
    write_reg(CFG_EXT_SHIFT, rnd8());
    random_phase(ITEMS_PER_PHASE);
    settle();

    write_reg(CFG_SHIFT, 8'hff);
    write_reg(CFG_EXT_SHIFT, 8'hff);
    random_phase(ITEMS_PER_PHASE);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
